// ===== hw/rtl/blr_pkg.sv =====
// ----------------------------------------------------------------------------
// blr_pkg: shared types and constants for the line rasterizer
// Opcode codes and default coordinate width.
// ----------------------------------------------------------------------------
`default_nettype none

package blr_pkg;

    // default coordinate width in bits
    localparam int BLR_COORD_BITS = 12;

    // operation carried in tuser
    typedef enum logic [0:0] {
        BLR_OP_LOAD = 1'b0,
        BLR_OP_STEP = 1'b1
    } blr_op_t;

endpackage : blr_pkg

`default_nettype wire

// ===== hw/rtl/blr_setup.sv =====
// ----------------------------------------------------------------------------
// blr_setup: line setup for a load item
// Finds the steep case, swaps the axes, orders the endpoints along the major
// axis and forms the error increment and decrement.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_setup
    import blr_pkg::*;
#(
    parameter int COORD_BITS = BLR_COORD_BITS
) (
    input  wire logic [COORD_BITS-1:0] start_x,
    input  wire logic [COORD_BITS-1:0] start_y,
    input  wire logic [COORD_BITS-1:0] end_x,
    input  wire logic [COORD_BITS-1:0] end_y,
    output logic                       steep,
    output logic [COORD_BITS-1:0]      major_pos,
    output logic [COORD_BITS-1:0]      major_end,
    output logic [COORD_BITS-1:0]      minor_pos,
    output logic                       minor_down,
    output logic [COORD_BITS:0]        error_inc,
    output logic [COORD_BITS:0]        error_dec
);

    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic [COORD_BITS-1:0] a0;
    logic [COORD_BITS-1:0] b0;
    logic [COORD_BITS-1:0] a1;
    logic [COORD_BITS-1:0] b1;
    logic [COORD_BITS-1:0] d_major;
    logic [COORD_BITS-1:0] d_minor;

    // absolute deltas
    assign adx = (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
    assign ady = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);

    // ties count as shallow
    assign steep = (adx < ady);

    // swap axes for steep lines
    always_comb begin
        if (steep) begin
            a0      = start_y;
            b0      = start_x;
            a1      = end_y;
            b1      = end_x;
            d_major = ady;
            d_minor = adx;
        end else begin
            a0      = start_x;
            b0      = start_y;
            a1      = end_x;
            b1      = end_y;
            d_major = adx;
            d_minor = ady;
        end
    end

    // order endpoints so the major coordinate rises
    always_comb begin
        if (a0 > a1) begin
            major_pos  = a1;
            major_end  = a0;
            minor_pos  = b1;
            minor_down = (b0 < b1);
        end else begin
            major_pos  = a0;
            major_end  = a1;
            minor_pos  = b0;
            minor_down = (b1 < b0);
        end
    end

    // twice the deltas
    assign error_inc = {d_minor, 1'b0};
    assign error_dec = {d_major, 1'b0};

endmodule : blr_setup

`default_nettype wire

// ===== hw/rtl/bresenham_line_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_core: streaming line rasterizer
//
//   channel | direction | tdata (low bit up)                  | tuser / tlast
//   s_axis  | in        | start_x, start_y, end_x, end_y       | tuser: opcode
//   m_axis  | out       | pixel_x, pixel_y                     | tlast: last_pixel
//
// An accepted item is held in the input register, then setup or one
// Bresenham step runs and a step's pixel lands in the output register.
// One item per clock unless stalled; steps pass the input, then the output register.
// The step loop (error add, compare, minor update) is combinational.
// Reset clears the input/output valids and drops any active line.
// A stalled output holds the input register, loads and idle steps included.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_rasterizer_core
    import blr_pkg::*;
#(
    parameter int COORD_BITS = BLR_COORD_BITS,
    localparam int S_DATA_W = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int M_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // start_x, start_y, end_x, end_y, zero pad
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    // opcode
    input  wire logic [0:0]          s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // pixel_x, pixel_y, zero pad
    output logic [M_DATA_W-1:0]      m_axis_tdata,
    output logic                     m_axis_tlast
);

    localparam int ERR_W = COORD_BITS + 3;

    // input register
    logic                  in_valid_reg;
    blr_op_t               in_op_reg;
    logic [COORD_BITS-1:0] in_x0_reg;
    logic [COORD_BITS-1:0] in_y0_reg;
    logic [COORD_BITS-1:0] in_x1_reg;
    logic [COORD_BITS-1:0] in_y1_reg;

    // line state
    logic                  active_reg;
    logic                  steep_reg;
    logic [COORD_BITS-1:0] major_pos_reg;
    logic [COORD_BITS-1:0] major_end_reg;
    logic [COORD_BITS-1:0] minor_pos_reg;
    logic                  minor_down_reg;
    logic [ERR_W-1:0]      error_reg;
    logic [COORD_BITS:0]   error_inc_reg;
    logic [COORD_BITS:0]   error_dec_reg;

    // output register
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic                  out_last_reg;

    // setup results
    logic                  su_steep;
    logic [COORD_BITS-1:0] su_major_pos;
    logic [COORD_BITS-1:0] su_major_end;
    logic [COORD_BITS-1:0] su_minor_pos;
    logic                  su_minor_down;
    logic [COORD_BITS:0]   su_error_inc;
    logic [COORD_BITS:0]   su_error_dec;

    // step logic
    logic                  advance;
    logic                  do_load;
    logic                  do_step;
    logic                  is_last;
    logic [ERR_W-1:0]      error_sum;
    logic [ERR_W-1:0]      half_dec;
    logic                  minor_move;
    logic [COORD_BITS-1:0] minor_next;
    logic [ERR_W-1:0]      error_next;

    // handshake: the held item moves on when the output slot is free or leaving
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign do_load       = advance && (in_op_reg == BLR_OP_LOAD);
    assign do_step       = advance && (in_op_reg == BLR_OP_STEP) && active_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_op_reg <= blr_op_t'(s_axis_tuser[0]);
            in_x0_reg <= s_axis_tdata[COORD_BITS-1:0];
            in_y0_reg <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
            in_x1_reg <= s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
            in_y1_reg <= s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
        end
    end

    // line setup
    blr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .start_x    (in_x0_reg),
        .start_y    (in_y0_reg),
        .end_x      (in_x1_reg),
        .end_y      (in_y1_reg),
        .steep      (su_steep),
        .major_pos  (su_major_pos),
        .major_end  (su_major_end),
        .minor_pos  (su_minor_pos),
        .minor_down (su_minor_down),
        .error_inc  (su_error_inc),
        .error_dec  (su_error_dec)
    );

    // one Bresenham step
    assign is_last    = (major_pos_reg == major_end_reg);
    assign error_sum  = error_reg + {2'b00, error_inc_reg};
    assign half_dec   = {3'b000, error_dec_reg[COORD_BITS:1]};
    assign minor_move = ($signed(error_sum) > $signed(half_dec));
    assign minor_next = minor_down_reg ? (minor_pos_reg - 1'b1) : (minor_pos_reg + 1'b1);
    assign error_next = minor_move ? (error_sum - {2'b00, error_dec_reg}) : error_sum;

    // line state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (do_load) begin
            active_reg <= 1'b1;
        end else if (do_step && is_last) begin
            active_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_load) begin
            steep_reg      <= su_steep;
            major_pos_reg  <= su_major_pos;
            major_end_reg  <= su_major_end;
            minor_pos_reg  <= su_minor_pos;
            minor_down_reg <= su_minor_down;
            error_reg      <= '0;
            error_inc_reg  <= su_error_inc;
            error_dec_reg  <= su_error_dec;
        end else if (do_step && !is_last) begin
            major_pos_reg <= major_pos_reg + 1'b1;
            error_reg     <= error_next;
            if (minor_move) begin
                minor_pos_reg <= minor_next;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (do_step) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_step) begin
            out_x_reg    <= steep_reg ? minor_pos_reg : major_pos_reg;
            out_y_reg    <= steep_reg ? major_pos_reg : minor_pos_reg;
            out_last_reg <= is_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = M_DATA_W'({out_y_reg, out_x_reg});

    // checks
    a_step_gives_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        do_step |=> m_axis_tvalid)
        else $error("step on an active line gave no pixel");

    a_load_activates: assert property (@(posedge aclk) disable iff (!aresetn)
        do_load |=> active_reg)
        else $error("load did not start a line");

    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_step && is_last) |=> !active_reg)
        else $error("line still active after its last pixel");

    a_error_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> ($signed(error_reg) <= $signed(half_dec)))
        else $error("error term above half the decrement");

    a_last_flag_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        do_step |=> (m_axis_tlast == $past(is_last)))
        else $error("last flag does not match the end of the line");

endmodule : bresenham_line_rasterizer_core

`default_nettype wire
